@@ sv/tifr_pkg.sv @@
// ---------------------------------------------------------------------------
// tifr_pkg: shared types and constants for the text/image frame receiver
// Event, phase, line matcher, key and header parser codes; helper functions.
// ---------------------------------------------------------------------------
package tifr_pkg;

  localparam int LEN_WIDTH_DEF = 24;

  localparam logic [1:0] EV_ACCEPT = 2'd0;
  localparam logic [1:0] EV_REJECT = 2'd1;
  localparam logic [1:0] EV_NEW    = 2'd2;

  localparam logic [1:0] PH_WAIT_JSON = 2'd0;
  localparam logic [1:0] PH_WAIT_HDR  = 2'd1;
  localparam logic [1:0] PH_READ      = 2'd2;
  localparam logic [1:0] PH_WAIT_END  = 2'd3;

  localparam logic [4:0] LM_START     = 5'd0;
  localparam logic [4:0] LM_DEAD      = 5'd1;
  localparam logic [4:0] LM_JSON_1    = 5'd2;
  localparam logic [4:0] LM_JSON_FULL = 5'd6;
  localparam logic [4:0] LM_JSON_OK   = 5'd7;
  localparam logic [4:0] LM_IMG_1     = 5'd8;
  localparam logic [4:0] LM_IMG_FULL  = 5'd13;
  localparam logic [4:0] LM_IMG_OK    = 5'd14;
  localparam logic [4:0] LM_END_1     = 5'd15;
  localparam logic [4:0] LM_END_2     = 5'd16;
  localparam logic [4:0] LM_END_OK    = 5'd17;

  localparam logic [3:0] KEY_FOUND = 4'd8;
  localparam logic [3:0] KEY_PLUS  = 4'd9;
  localparam logic [3:0] KEY_DIG   = 4'd10;
  localparam logic [3:0] KEY_DONE  = 4'd11;

  localparam logic [3:0] HP_WS_LEN  = 4'd0;
  localparam logic [3:0] HP_LEN_SGN = 4'd1;
  localparam logic [3:0] HP_LEN_DIG = 4'd2;
  localparam logic [3:0] HP_WS_CRC  = 4'd3;
  localparam logic [3:0] HP_CRC_SGN = 4'd4;
  localparam logic [3:0] HP_CRC_ZERO = 4'd5;
  localparam logic [3:0] HP_CRC_PFX = 4'd6;
  localparam logic [3:0] HP_CRC_DIG = 4'd7;
  localparam logic [3:0] HP_DONE    = 4'd8;

  localparam logic [7:0] CH_LF = 8'h0A;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= "0") && (c <= "9");
  endfunction

  // hex value in [3:0], valid flag in [4]
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      hex_val = 5'd0;
      if (c >= "0" && c <= "9") begin
        d = c - 8'h30;
        hex_val = {1'b1, d[3:0]};
      end else if (c >= "a" && c <= "f") begin
        d = c - 8'h57;
        hex_val = {1'b1, d[3:0]};
      end else if (c >= "A" && c <= "F") begin
        d = c - 8'h37;
        hex_val = {1'b1, d[3:0]};
      end
    end
  endfunction

  function automatic logic [7:0] kw_json(input logic [4:0] m);
    case (m)
      5'd1: kw_json = "S";
      5'd2: kw_json = "O";
      5'd3: kw_json = "N";
      5'd4: kw_json = " ";
      default: kw_json = "J";
    endcase
  endfunction

  function automatic logic [7:0] kw_image(input logic [4:0] m);
    case (m)
      5'd1: kw_image = "M";
      5'd2: kw_image = "A";
      5'd3: kw_image = "G";
      5'd4: kw_image = "E";
      5'd5: kw_image = " ";
      default: kw_image = "I";
    endcase
  endfunction

  function automatic logic [7:0] kw_key(input logic [3:0] k);
    case (k)
      4'd1: kw_key = "f";
      4'd2: kw_key = "r";
      4'd3: kw_key = "a";
      4'd4: kw_key = "m";
      4'd5: kw_key = "e";
      4'd6: kw_key = 8'h22;
      4'd7: kw_key = ":";
      default: kw_key = 8'h22;
    endcase
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] x;
    begin
      x = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++)
        x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
      crc_byte = x;
    end
  endfunction

endpackage

@@ sv/tifr_if.sv @@
// ---------------------------------------------------------------------------
// tifr_byte_if / tifr_res_if: valid/ready channels of the frame receiver
// Byte input channel and result channel.
// ---------------------------------------------------------------------------
interface tifr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tifr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [31:0] frame_number;
  logic [23:0] payload_count;
  logic [31:0] computed_crc;
  modport source (output valid, output event_res, output frame_number,
                  output payload_count, output computed_crc, input ready);
  modport sink   (input valid, input event_res, input frame_number,
                  input payload_count, input computed_crc, output ready);
endinterface

@@ sv/tifr_parser.sv @@
// ---------------------------------------------------------------------------
// tifr_parser: per-byte line matcher, key/header parser and frame control
// Updates all frame state for one registered byte and forms the result.
// ---------------------------------------------------------------------------
module tifr_parser #(
  parameter int LEN_WIDTH = tifr_pkg::LEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  c,
  output logic        res_valid,
  output logic [1:0]  res_event,
  output logic [31:0] res_frame,
  output logic [23:0] res_count,
  output logic [31:0] res_crc
);
  import tifr_pkg::*;

  localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

  logic [1:0]  phase, phase_next;
  logic [4:0]  lm, lm_next;
  logic [3:0]  key, key_next;
  logic [3:0]  hp, hp_next;
  logic [LEN_WIDTH-1:0] exp_len, exp_len_next;
  logic [31:0] exp_crc, exp_crc_next;
  logic [31:0] run_crc, run_crc_next;
  logic [31:0] cap_cnt, cap_cnt_next;
  logic [31:0] cur_frame, cur_frame_next;
  logic [31:0] pend_frame, pend_frame_next;
  logic [LEN_WIDTH-1:0] pend_len, pend_len_next;
  logic [31:0] pend_crc, pend_crc_next;

  logic [4:0]  h;
  logic [3:0]  dv;
  logic [LEN_WIDTH+3:0] len_x10;
  logic [31:0] crc_fin;

  assign h = hex_val(c);
  assign dv = c[3:0];
  assign len_x10 = {4'd0, pend_len} * (LEN_WIDTH+4)'(10) + {{LEN_WIDTH{1'b0}}, dv};
  assign crc_fin = ~run_crc;

  always_comb begin
    phase_next = phase; lm_next = lm; key_next = key; hp_next = hp;
    exp_len_next = exp_len; exp_crc_next = exp_crc; run_crc_next = run_crc;
    cap_cnt_next = cap_cnt; cur_frame_next = cur_frame;
    pend_frame_next = pend_frame; pend_len_next = pend_len; pend_crc_next = pend_crc;
    res_valid = 1'b0; res_event = EV_NEW; res_frame = cur_frame;
    res_count = 24'd0; res_crc = 32'd0;

    if (phase == PH_READ) begin
      run_crc_next = crc_byte(run_crc, c);
      if (cap_cnt != 32'hFFFF_FFFF) cap_cnt_next = cap_cnt + 32'd1;
      if (cap_cnt_next >= {{(32-LEN_WIDTH){1'b0}}, exp_len}) phase_next = PH_WAIT_END;
    end else if (c != CH_LF) begin
      // line keyword matcher
      if (lm == LM_START) begin
        if (!is_ws(c))
          lm_next = (c == "J") ? LM_JSON_1 : (c == "I") ? LM_IMG_1 :
                    (c == "E") ? LM_END_1 : LM_DEAD;
      end else if (lm >= LM_JSON_1 && lm <= 5'd5) begin
        lm_next = (c == kw_json(lm - 5'd1)) ? lm + 5'd1 : LM_DEAD;
      end else if (lm == LM_JSON_FULL || lm == LM_IMG_FULL) begin
        if (!is_ws(c)) lm_next = lm + 5'd1;
      end else if (lm >= LM_IMG_1 && lm <= 5'd12) begin
        lm_next = (c == kw_image(lm - 5'd7)) ? lm + 5'd1 : LM_DEAD;
      end else if (lm == LM_END_1) begin
        lm_next = (c == "N") ? LM_END_2 : LM_DEAD;
      end else if (lm == LM_END_2) begin
        lm_next = (c == "D") ? LM_END_OK : LM_DEAD;
      end else if (lm == LM_END_OK) begin
        if (!is_ws(c)) lm_next = LM_DEAD;
      end

      if (lm == LM_JSON_FULL || lm == LM_JSON_OK) begin
        if (key < KEY_FOUND) begin
          if (c == kw_key(key)) begin
            key_next = key + 4'd1;
            if (key == 4'd7) pend_frame_next = 32'd0;
          end else if (key == 4'd7 && c == "f") key_next = 4'd2;
          else key_next = (c == 8'h22) ? 4'd1 : 4'd0;
        end else if (key == KEY_FOUND) begin
          if (!is_ws(c)) begin
            if (c == "+") key_next = KEY_PLUS;
            else if (is_dig(c)) begin
              pend_frame_next = {28'd0, dv}; key_next = KEY_DIG;
            end else key_next = KEY_DONE;
          end
        end else if (key == KEY_PLUS) begin
          if (is_dig(c)) begin
            pend_frame_next = {28'd0, dv}; key_next = KEY_DIG;
          end else key_next = KEY_DONE;
        end else if (key == KEY_DIG) begin
          if (is_dig(c)) pend_frame_next = pend_frame * 32'd10 + {28'd0, dv};
          else key_next = KEY_DONE;
        end
      end else if (lm == LM_IMG_FULL || lm == LM_IMG_OK) begin
        case (hp)
          HP_WS_LEN: if (!is_ws(c)) begin
            if (c == "+") hp_next = HP_LEN_SGN;
            else if (is_dig(c)) begin
              pend_len_next = LEN_WIDTH'(dv); hp_next = HP_LEN_DIG;
            end else hp_next = HP_DONE;
          end
          HP_LEN_SGN: if (is_dig(c)) begin
            pend_len_next = LEN_WIDTH'(dv); hp_next = HP_LEN_DIG;
          end else hp_next = HP_DONE;
          HP_LEN_DIG, HP_WS_CRC: begin
            if (hp == HP_LEN_DIG && is_dig(c)) begin
              pend_len_next = (len_x10 > {4'd0, LEN_MAX}) ? LEN_MAX
                              : len_x10[LEN_WIDTH-1:0];
            end else begin
              hp_next = HP_WS_CRC;
              if (!is_ws(c)) begin
                if (c == "+") hp_next = HP_CRC_SGN;
                else if (c == "0") begin
                  pend_crc_next = 32'd0; hp_next = HP_CRC_ZERO;
                end else if (h[4]) begin
                  pend_crc_next = {28'd0, h[3:0]}; hp_next = HP_CRC_DIG;
                end else hp_next = HP_DONE;
              end
            end
          end
          HP_CRC_SGN: begin
            if (c == "0") begin
              pend_crc_next = 32'd0; hp_next = HP_CRC_ZERO;
            end else if (h[4]) begin
              pend_crc_next = {28'd0, h[3:0]}; hp_next = HP_CRC_DIG;
            end else hp_next = HP_DONE;
          end
          HP_CRC_ZERO: begin
            if (c == "x" || c == "X") hp_next = HP_CRC_PFX;
            else if (h[4]) begin
              pend_crc_next = {28'd0, h[3:0]}; hp_next = HP_CRC_DIG;
            end else hp_next = HP_DONE;
          end
          HP_CRC_PFX: begin
            if (h[4]) begin
              pend_crc_next = {28'd0, h[3:0]}; hp_next = HP_CRC_DIG;
            end else hp_next = HP_DONE;
          end
          HP_CRC_DIG: begin
            if (h[4]) pend_crc_next = {pend_crc[27:0], h[3:0]};
            else hp_next = HP_DONE;
          end
          default: ;
        endcase
      end
    end else begin
      // end of line
      if (lm == LM_JSON_OK) begin
        exp_len_next = '0; exp_crc_next = 32'd0; run_crc_next = 32'hFFFF_FFFF;
        cap_cnt_next = 32'd0;
        if (key >= KEY_FOUND) cur_frame_next = pend_frame;
        phase_next = PH_WAIT_HDR;
        res_valid = 1'b1; res_event = EV_NEW; res_frame = cur_frame_next;
      end else if (phase == PH_WAIT_HDR && lm == LM_IMG_OK) begin
        exp_len_next = pend_len; exp_crc_next = pend_crc;
        run_crc_next = 32'hFFFF_FFFF; cap_cnt_next = 32'd0;
        phase_next = PH_READ;
      end else if (phase == PH_WAIT_END && lm == LM_END_OK) begin
        res_valid = 1'b1;
        res_event = (crc_fin == exp_crc) ? EV_ACCEPT : EV_REJECT;
        res_count = cap_cnt[23:0]; res_crc = crc_fin;
        exp_len_next = '0; exp_crc_next = 32'd0; run_crc_next = 32'hFFFF_FFFF;
        cap_cnt_next = 32'd0; phase_next = PH_WAIT_JSON;
      end
      lm_next = LM_START; key_next = 4'd0; hp_next = HP_WS_LEN;
      pend_frame_next = 32'd0; pend_len_next = '0; pend_crc_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT_JSON; lm <= LM_START; key <= 4'd0; hp <= HP_WS_LEN;
      exp_len <= '0; exp_crc <= 32'd0; run_crc <= 32'hFFFF_FFFF; cap_cnt <= 32'd0;
      cur_frame <= 32'd0; pend_frame <= 32'd0; pend_len <= '0; pend_crc <= 32'd0;
    end else if (step) begin
      phase <= phase_next; lm <= lm_next; key <= key_next; hp <= hp_next;
      exp_len <= exp_len_next; exp_crc <= exp_crc_next; run_crc <= run_crc_next;
      cap_cnt <= cap_cnt_next; cur_frame <= cur_frame_next;
      pend_frame <= pend_frame_next; pend_len <= pend_len_next; pend_crc <= pend_crc_next;
    end
  end
endmodule

@@ sv/text_image_frame_receiver_core.sv @@
// ---------------------------------------------------------------------------
// text_image_frame_receiver_core: line-oriented text/image frame receiver
// Parses JSON/IMAGE/END lines, captures and CRC-checks the payload.
// ---------------------------------------------------------------------------
// Usage:
//   in  : one received byte per transaction (rx_byte).
//   out : at most one result per byte: new frame (on a JSON line end),
//         accept or reject (on an END line end), with frame id, payload
//         count and computed CRC.
//   A byte is registered on accept and parsed from the input register;
//   its result is loaded into the output register when the input stage
//   advances, and out valid then rises.
//   Throughput: one byte per cycle while the output is not stalled; the
//   byte-wide CRC and the line matchers are combinational.
//   Reset (rst, synchronous) empties both registers and returns the
//   parser to waiting for a JSON line with frame id 0.
//   A stalled receiver holds the result; the input register then drains
//   into the output register only when it is empty or being read, and
//   the byte channel backs up one stage later.
// ---------------------------------------------------------------------------
module text_image_frame_receiver_core #(
  parameter int LEN_WIDTH = tifr_pkg::LEN_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  tifr_byte_if.sink  in_ch,
  tifr_res_if.source out_ch
);
  import tifr_pkg::*;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        step;
  logic        r_valid;
  logic [1:0]  r_event;
  logic [31:0] r_frame;
  logic [23:0] r_count;
  logic [31:0] r_crc;
  logic        out_full;

  // input stage advances when the output register can take a result
  assign step = in_full && (!out_full || out_ch.ready);
  assign in_ch.ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) in_full <= 1'b0;
    else if (in_ch.ready) in_full <= in_ch.valid;
    if (in_ch.valid && in_ch.ready) in_byte <= in_ch.rx_byte;
  end

  tifr_parser #(.LEN_WIDTH(LEN_WIDTH)) u_parser (
    .clk(clk), .rst(rst), .step(step), .c(in_byte),
    .res_valid(r_valid), .res_event(r_event), .res_frame(r_frame),
    .res_count(r_count), .res_crc(r_crc)
  );

  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (step) out_full <= r_valid;
    else if (out_ch.ready) out_full <= 1'b0;
    if (step && r_valid) begin
      out_ch.event_res     <= r_event;
      out_ch.frame_number  <= r_frame;
      out_ch.payload_count <= r_count;
      out_ch.computed_crc  <= r_crc;
    end
  end

  assign out_ch.valid = out_full;

  a_no_step_stall: assert property (@(posedge clk) disable iff (rst)
    out_full && !out_ch.ready |-> !step) else $error("step into stalled output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_full && !out_ch.ready |=> out_full && $stable(out_ch.frame_number))
    else $error("result lost under stall");
  a_new_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_full && out_ch.event_res == EV_NEW |-> out_ch.payload_count == 24'd0)
    else $error("new frame event with payload count");
endmodule
